// ----- sv/prsf_pkg.sv -----
// ----------------------------------------------------------------------------
// prsf_pkg: shared types and constants of the point region slice filter
// Holds the transaction payload structs, command codes and region kinds.
// ----------------------------------------------------------------------------
package prsf_pkg;

  localparam logic [1:0] CMD_CLASSIFY = 2'd0;
  localparam logic [1:0] CMD_BOUND    = 2'd1;
  localparam logic [1:0] CMD_KIND     = 2'd2;

  localparam logic [1:0] KIND_BOX  = 2'd0;
  localparam logic [1:0] KIND_VOID = 2'd1;
  localparam logic [1:0] KIND_ELL  = 2'd2;
  localparam logic [1:0] KIND_CYL  = 2'd3;

  localparam int WORDS_PER_REGION = 6;

  localparam logic [2:0] REG_COUNT  = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_CX     = 3'd2;
  localparam logic [2:0] REG_CY     = 3'd3;
  localparam logic [2:0] REG_CZ     = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         region_index;
    logic [2:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [5:0]         material;
  } in_item_t;

  typedef struct packed {
    logic       keep;
    logic       removed;
    logic [2:0] matched_region;
  } out_item_t;

endpackage

// ----- sv/prsf_region_eval.sv -----
// ----------------------------------------------------------------------------
// prsf_region_eval: region sequencer over the bound memory
// Walks the regions of one point, reading bound words from a synchronous
// memory and forming ellipse sums on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module prsf_region_eval #(
  parameter int MAX_REGIONS = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  prsf_pkg::in_item_t   item,
  input  logic [3:0]           count,
  input  logic [31:0]          centre_x,
  input  logic [31:0]          centre_y,
  input  logic [31:0]          centre_z,
  output logic                 busy,
  output logic                 done,
  output logic                 hit,
  output logic [2:0]           hit_region
);

  localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int DEPTH = MAX_REGIONS * prsf_pkg::WORDS_PER_REGION;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int NW = $clog2(MAX_REGIONS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KIND  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_SQLL  = 4'd4;
  localparam logic [3:0] S_SQLH  = 4'd5;
  localparam logic [3:0] S_SQHH  = 4'd6;
  localparam logic [3:0] S_RLO   = 4'd7;
  localparam logic [3:0] S_RHI   = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_BOX   = 4'd10;
  localparam logic [3:0] S_DEC   = 4'd11;

  logic [1:0]  kind_mem [MAX_REGIONS];
  logic [31:0] bound_mem [DEPTH];
  logic [1:0]  kind_q;
  logic [31:0] bound_q;

  logic [3:0]    state;
  logic [RW-1:0] region;
  logic [2:0]    word;
  logic [1:0]    axis;
  logic [NW-1:0] n_act;
  logic [1:0]    kind;
  logic [31:0]   lo_w;
  logic          box_ok;
  logic [32:0]   mag;
  logic [65:0]   sq;
  logic [63:0]   prod;
  logic [97:0]   term;
  logic [99:0]   sum;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  // Writes come from the command channel only while the sequencer is idle.
  logic wr_bound, wr_kind;
  assign wr_bound = start && item.cmd == prsf_pkg::CMD_BOUND &&
                    {29'd0, item.region_index} < 32'(MAX_REGIONS) &&
                    item.word_index < 3'(prsf_pkg::WORDS_PER_REGION);
  assign wr_kind  = start && item.cmd == prsf_pkg::CMD_KIND &&
                    {29'd0, item.region_index} < 32'(MAX_REGIONS);

  always_ff @(posedge clk) begin
    if (wr_bound)
      bound_mem[AW'(32'(item.region_index) * prsf_pkg::WORDS_PER_REGION +
                    32'(item.word_index))] <= item.word_value;
    if (wr_kind) kind_mem[RW'(item.region_index)] <= item.word_value[1:0];
    if (rd_en) bound_q <= bound_mem[rd_addr];
    kind_q <= kind_mem[region];
  end

  function automatic logic signed [32:0] cx(input logic [31:0] v);
    logic [CW-1:0] t;
    t = v[CW-1:0];
    return 33'(signed'(t));
  endfunction

  logic [31:0] pt, ct;
  always_comb begin
    case (axis)
      2'd0:    begin pt = item.point_x; ct = centre_x; end
      2'd1:    begin pt = item.point_y; ct = centre_y; end
      default: begin pt = item.point_z; ct = centre_z; end
    endcase
  end

  // Multiplier operand selection: one 32x32 product per cycle.
  logic [31:0] ma, mb;
  always_comb begin
    case (state)
      S_SQLL:  begin ma = mag[31:0]; mb = mag[31:0]; end
      S_SQLH:  begin ma = mag[31:0]; mb = {31'd0, mag[32]}; end
      S_RLO:   begin ma = sq[31:0];  mb = bound_q; end
      S_RHI:   begin ma = sq[63:32]; mb = bound_q; end
      default: begin ma = 32'd0;     mb = 32'd0; end
    endcase
  end
  always_ff @(posedge clk) prod <= ma * mb;

  logic signed [32:0] dd;
  assign dd = cx(pt) - cx(ct);

  always_comb begin
    rd_en = 1'b1;
    rd_addr = AW'(32'(region) * prsf_pkg::WORDS_PER_REGION + 32'(word));
  end

  logic last;
  assign last = 32'(region) + 1 >= 32'(n_act);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start && item.cmd == prsf_pkg::CMD_CLASSIFY) begin
          n_act <= (32'(count) > MAX_REGIONS) ? NW'(MAX_REGIONS) : NW'(count);
          region <= '0;
          state <= S_KIND;
        end
        S_KIND: begin
          word <= 3'd0; axis <= 2'd0; sum <= '0; box_ok <= 1'b1;
          state <= S_RD;
        end
        S_RD: begin
          kind <= kind_q;
          state <= (kind_q == prsf_pkg::KIND_BOX || kind_q == prsf_pkg::KIND_VOID ||
                    (kind_q == prsf_pkg::KIND_CYL && word >= 3'd2)) ? S_BOX : S_DIFF;
        end
        S_DIFF: begin
          mag <= dd[32] ? 33'(-dd) : 33'(dd);
          state <= S_SQLL;
        end
        S_SQLL: state <= S_SQLH;
        S_SQLH: begin sq <= {2'd0, prod}; state <= S_SQHH; end
        S_SQHH: begin
          sq <= sq + (66'(prod) << 33) + {mag[32], 64'd0};
          state <= S_RLO;
        end
        S_RLO: state <= S_RHI;
        S_RHI: begin term <= {34'd0, prod}; state <= S_ACC; end
        S_ACC: begin
          sum <= sum + 100'(term) + (100'(prod) << 32) +
                 (100'(sq[65:64] * bound_q) << 64);
          if ((kind == prsf_pkg::KIND_ELL && axis == 2'd2) ||
              (kind == prsf_pkg::KIND_CYL && axis == 2'd1)) begin
            state <= S_DEC;
            if (kind == prsf_pkg::KIND_CYL) begin
              word <= 3'd2; state <= S_KIND + 4'd0;
            end
          end else begin
            axis <= axis + 2'd1; word <= word + 3'd1; state <= S_KIND + 4'd1;
          end
          if (kind == prsf_pkg::KIND_CYL && axis == 2'd1) begin
            axis <= 2'd2; word <= 3'd2; state <= S_RD;
          end
        end
        S_BOX: begin
          if (!word[0]) begin
            lo_w <= bound_q;
          end else if (cx(pt) < cx(lo_w) || cx(pt) > cx(bound_q)) begin
            box_ok <= 1'b0;
          end
          if (word == 3'd5 || (kind == prsf_pkg::KIND_CYL && word == 3'd3)) begin
            state <= S_DEC;
          end else begin
            word <= word + 3'd1;
            if (word[0]) axis <= axis + 2'd1;
            state <= S_RD;
          end
        end
        S_DEC: begin
          logic acc;
          acc = (kind == prsf_pkg::KIND_BOX)  ? box_ok :
                (kind == prsf_pkg::KIND_VOID) ? !box_ok :
                (kind == prsf_pkg::KIND_ELL)  ? (sum <= 100'(1) << 56) :
                (box_ok && sum <= 100'(1) << 56);
          if (acc || last) begin
            hit <= acc;
            hit_region <= acc ? 3'(region) : 3'd0;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            region <= region + RW'(1);
            state <= S_KIND;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    !(done && state != S_IDLE)) else $error("done outside idle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    !(start && busy)) else $error("start while busy");
  a_stray_region: assert property (@(posedge clk) disable iff (rst)
    !(done && !hit && hit_region != 3'd0)) else $error("stray region");

endmodule

// ----- sv/point_region_slice_filter_top.sv -----
// ----------------------------------------------------------------------------
// point_region_slice_filter_top: point in region filter
// Classifies Q16.16 points against up to MAX_REGIONS stored regions.
// ----------------------------------------------------------------------------
// A classify transaction raises out_valid once the regions have been walked
// in order up to the first hit, each step paced by the bound word memory
// read port and the single shared 32x32 multiplier; a removed point or a
// zero region count raises out_valid without a walk. Bound and kind writes
// give no result transaction. One transaction is in work at a time; a
// finished result waits in the output register, and while that waiting
// result is stalled no next input is accepted and no next transaction starts.
module point_region_slice_filter_top #(
  parameter int MAX_REGIONS = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  prsf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prsf_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  logic [3:0]  region_count;
  logic [63:0] remove_mask;
  logic [31:0] centre_x, centre_y, centre_z;

  // Registers sit at 8 byte spacing since the remove mask is 64 bits wide.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0; remove_mask <= '0;
      centre_x <= '0; centre_y <= '0; centre_z <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        prsf_pkg::REG_COUNT: region_count <= pwdata[3:0];
        prsf_pkg::REG_MASK:  remove_mask <= pwdata;
        prsf_pkg::REG_CX:    centre_x <= pwdata[31:0];
        prsf_pkg::REG_CY:    centre_y <= pwdata[31:0];
        prsf_pkg::REG_CZ:    centre_z <= pwdata[31:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[5:3])
      prsf_pkg::REG_COUNT: prdata = {60'd0, region_count};
      prsf_pkg::REG_MASK:  prdata = remove_mask;
      prsf_pkg::REG_CX:    prdata = {32'd0, centre_x};
      prsf_pkg::REG_CY:    prdata = {32'd0, centre_y};
      prsf_pkg::REG_CZ:    prdata = {32'd0, centre_z};
      default:             prdata = 64'd0;
    endcase
  end

  // The accepted transaction is held here for the whole evaluation.
  prsf_pkg::in_item_t item;
  logic pending;     // an accepted transaction not yet started
  logic start, busy, done, hit;
  logic [2:0] hit_region;
  logic eval_start;

  // A transaction starts only when the output register is free or is being
  // emptied at the same edge, so its result can never overwrite a waiting one.
  assign in_stall = pending || busy || out_valid && out_stall;
  assign start = pending && !busy && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) pending <= 1'b0;
    else if (in_valid && !in_stall) begin
      pending <= 1'b1;
      item <= in_data;
    end else if (start) pending <= 1'b0;
  end

  logic removed_now, fast_keep;
  assign removed_now = remove_mask[item.material];
  assign fast_keep = region_count == 4'd0;
  assign eval_start = start && !(item.cmd == prsf_pkg::CMD_CLASSIFY &&
                                 (removed_now || fast_keep));

  prsf_region_eval #(.MAX_REGIONS(MAX_REGIONS), .COORD_WIDTH(COORD_WIDTH)) u_eval (
    .clk, .rst, .start(eval_start), .item, .count(region_count),
    .centre_x, .centre_y, .centre_z,
    .busy, .done, .hit, .hit_region
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (start && item.cmd == prsf_pkg::CMD_CLASSIFY && (removed_now || fast_keep)) begin
        out_valid <= 1'b1;
        out_data <= '{keep: !removed_now, removed: removed_now, matched_region: 3'd0};
      end else if (done) begin
        out_valid <= 1'b1;
        out_data <= '{keep: hit, removed: 1'b0, matched_region: hit_region};
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(done && out_valid && out_stall)) else $error("result overrun");
  a_single_accept: assert property (@(posedge clk) disable iff (rst)
    !(pending && in_valid && !in_stall)) else $error("double accept");
  a_keep_removed: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_data.keep && out_data.removed)) else $error("keep and removed");

endmodule

// ----- tb/point_region_slice_filter_top_tb.sv -----
// ----------------------------------------------------------------------------
// point_region_slice_filter_top_tb: self-checking bench of the region filter
// Loads region tables through the command input, sets the registers over the
// APB port, and checks every classify result against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_region_slice_filter_top_tb;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  prsf_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  prsf_pkg::out_item_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [5:0]          paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;

  point_region_slice_filter_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of the configuration and the region table.
  logic [3:0]         cfg_count;
  logic [63:0]        cfg_mask;
  logic signed [31:0] cfg_cx, cfg_cy, cfg_cz;
  logic [1:0]         kind_tbl [8];
  logic [31:0]        bound_tbl [48];

  prsf_pkg::out_item_t verdict_q[$];
  int        fail_count;
  int        checked_count;
  int        cycle_count;
  // Idle percentages for the two sides; set per phase.
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact Q40.56 ellipse term: (p - c)^2 * r with r unsigned Q8.24.
  function automatic logic [127:0] ell_term(logic signed [31:0] p,
                                            logic signed [31:0] c,
                                            logic [31:0] r);
    logic signed [63:0] d;
    logic [63:0]        a;
    d = 64'(p) - 64'(c);
    a = d[63] ? -d : d;
    return 128'(a) * 128'(a) * 128'(r);
  endfunction

  function automatic bit in_span(logic signed [31:0] v, logic [31:0] lo,
                                 logic [31:0] hi);
    return v >= $signed(lo) && v <= $signed(hi);
  endfunction

  function automatic bit region_hit(int r, prsf_pkg::in_item_t it);
    logic [127:0] s;
    bit           in_box;
    int           b;
    b = r * prsf_pkg::WORDS_PER_REGION;
    case (kind_tbl[r])
      prsf_pkg::KIND_BOX, prsf_pkg::KIND_VOID: begin
        in_box = in_span(it.point_x, bound_tbl[b], bound_tbl[b+1]) &&
                 in_span(it.point_y, bound_tbl[b+2], bound_tbl[b+3]) &&
                 in_span(it.point_z, bound_tbl[b+4], bound_tbl[b+5]);
        return (kind_tbl[r] == prsf_pkg::KIND_BOX) ? in_box : !in_box;
      end
      prsf_pkg::KIND_ELL: begin
        s = ell_term(it.point_x, cfg_cx, bound_tbl[b]) +
            ell_term(it.point_y, cfg_cy, bound_tbl[b+1]) +
            ell_term(it.point_z, cfg_cz, bound_tbl[b+2]);
        return s <= (128'd1 << 56);
      end
      default: begin
        s = ell_term(it.point_x, cfg_cx, bound_tbl[b]) +
            ell_term(it.point_y, cfg_cy, bound_tbl[b+1]);
        return s <= (128'd1 << 56) && in_span(it.point_z, bound_tbl[b+2], bound_tbl[b+3]);
      end
    endcase
  endfunction

  // Updates the table for writes and returns 1 with a verdict for classifies.
  function automatic bit filter_point(prsf_pkg::in_item_t it,
                                      output prsf_pkg::out_item_t res);
    int n;
    res = '0;
    case (it.cmd)
      prsf_pkg::CMD_BOUND: begin
        if (it.word_index < prsf_pkg::WORDS_PER_REGION)
          bound_tbl[it.region_index * prsf_pkg::WORDS_PER_REGION + it.word_index] =
            it.word_value;
        return 1'b0;
      end
      prsf_pkg::CMD_KIND: begin
        kind_tbl[it.region_index] = it.word_value[1:0];
        return 1'b0;
      end
      prsf_pkg::CMD_CLASSIFY: begin
        if (cfg_mask[it.material]) begin
          res.removed = 1'b1;
          return 1'b1;
        end
        n = (cfg_count > 8) ? 8 : cfg_count;
        if (n == 0) begin
          res.keep = 1'b1;
          return 1'b1;
        end
        for (int r = 0; r < n; r++) begin
          if (region_hit(r, it)) begin
            res.keep = 1'b1;
            res.matched_region = 3'(r);
            return 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Drives one transaction; the predictor runs when the block accepts it.
  // Valid stays high after acceptance until the next call drives a new item or drain lowers it.
  task automatic send_item(prsf_pkg::in_item_t it, bit typed_known = 1'b0,
                           prsf_pkg::out_item_t typed = '0);
    prsf_pkg::out_item_t res;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (filter_point(it, res)) begin
      // Rows with a typed answer must also agree with the predictor.
      if (typed_known && res !== typed) begin
        $display("%0t predictor disagrees with table: expected %p, actual %p",
                 $time, typed, res);
        fail_count++;
      end
      verdict_q = {verdict_q, res};
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      prsf_pkg::REG_COUNT: cfg_count = val[3:0];
      prsf_pkg::REG_MASK:  cfg_mask  = val;
      prsf_pkg::REG_CX:    cfg_cx    = val[31:0];
      prsf_pkg::REG_CY:    cfg_cy    = val[31:0];
      default:             cfg_cz    = val[31:0];
    endcase
  endtask

  // Waits for every expected verdict, then lets a write finish inside the
  // block, since a write gives no result transaction to wait on.
  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic prsf_pkg::in_item_t mk(logic [1:0] c, logic [2:0] ri,
                                            logic [2:0] wi, logic [31:0] wv);
    prsf_pkg::in_item_t it;
    it = '0;
    it.cmd = c; it.region_index = ri; it.word_index = wi; it.word_value = wv;
    return it;
  endfunction

  function automatic prsf_pkg::in_item_t mk_point(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [5:0] m);
    prsf_pkg::in_item_t it;
    it = '0;
    it.cmd = prsf_pkg::CMD_CLASSIFY; it.point_x = x; it.point_y = y; it.point_z = z;
    it.material = m;
    it.region_index = 3'($urandom); it.word_index = 3'($urandom);
    it.word_value = $urandom;
    return it;
  endfunction

  // Random coordinate: mostly near the origin so region edges get hit.
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  // Writes a whole region: kind plus six words with random but plausible
  // content for that kind.
  task automatic load_region(int r, logic [1:0] k);
    logic signed [31:0] lo, hi;
    send_item(mk(prsf_pkg::CMD_KIND, 3'(r), 3'd0, {$urandom} & ~32'h3 | 32'(k)));
    for (int w = 0; w < prsf_pkg::WORDS_PER_REGION; w++) begin
      lo = rnd_coord();
      if ((k == prsf_pkg::KIND_ELL && w < 3) || (k == prsf_pkg::KIND_CYL && w < 2)) begin
        // Reciprocal squared semi-axis: 1/a^2 for a between ~0.5 and ~4.
        hi = $urandom_range(9) == 0 ? $urandom : $urandom_range(32'h0010_0000, 32'h0400_0000);
      end else if (w % 2 == 0 || (k == prsf_pkg::KIND_CYL && w == 2)) begin
        hi = lo;
      end else begin
        hi = bound_tbl[r * prsf_pkg::WORDS_PER_REGION + w - 1] +
             $urandom_range(0, 32'h0006_0000);
        if ($urandom_range(19) == 0) hi = $urandom;
      end
      send_item(mk(prsf_pkg::CMD_BOUND, 3'(r), 3'(w), hi));
    end
  endtask

  typedef struct {
    prsf_pkg::in_item_t  it;
    bit                  known;
    prsf_pkg::out_item_t res;
  } row_t;

  row_t stim_rows[$];

  // Appends one stimulus row to the directed table.
  task automatic add_row(prsf_pkg::in_item_t it, bit known, prsf_pkg::out_item_t res);
    row_t r;
    r.it = it; r.known = known; r.res = res;
    stim_rows = {stim_rows, r};
  endtask

  // Receiver: stalls at random, and once holds off for a long stretch.
  initial begin
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      @(negedge clk);
    end
  end

  // Checker: compares every accepted verdict with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        if (out_data.keep !== verdict_q[0].keep ||
            out_data.removed !== verdict_q[0].removed ||
            out_data.matched_region !== verdict_q[0].matched_region) begin
          $display("%0t mismatch: expected %p, actual %p", $time, verdict_q[0], out_data);
          fail_count++;
        end
        void'(verdict_q.pop_front());
        checked_count++;
      end
    end
  end

  // Watchdog on a cycle counter.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, verdict_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t                rw;
    prsf_pkg::out_item_t kept, dropped;
    int                  phase;
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    fail_count = 0; checked_count = 0;
    cfg_count = '0; cfg_mask = '0; cfg_cx = '0; cfg_cy = '0; cfg_cz = '0;
    foreach (kind_tbl[i]) kind_tbl[i] = prsf_pkg::KIND_BOX;
    foreach (bound_tbl[i]) bound_tbl[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    kept = '0; kept.keep = 1'b1;
    dropped = '0; dropped.removed = 1'b1;

    // Directed table. After reset no regions are active, so every point is
    // kept; writes go in before any region becomes active.
    add_row(mk_point(32'h7fffffff, 32'h80000000, 32'h0, 6'd0), 1, kept);
    add_row(mk_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 6'd63), 1, kept);
    // Region 0: unit box around the origin.
    add_row(mk(prsf_pkg::CMD_KIND, 3'd0, 3'd0, 32'(prsf_pkg::KIND_BOX)), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd0, 32'hffff0000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd1, 32'h00010000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd2, 32'hffff0000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd3, 32'h00010000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd4, 32'hffff0000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd5, 32'h00010000), 0, '0);
    // Word slot beyond the last is ignored; reserved command does nothing.
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd7, 32'h12345678), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd0, 3'd6, 32'hdeadbeef), 0, '0);
    add_row(mk(2'd3, 3'd7, 3'd7, 32'hffffffff), 0, '0);
    // Region 1: ellipsoid with unit axes; negative kind value uses low bits.
    add_row(mk(prsf_pkg::CMD_KIND, 3'd1, 3'd0, 32'hfffffffe), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd1, 3'd0, 32'h01000000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd1, 3'd1, 32'h01000000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd1, 3'd2, 32'h01000000), 0, '0);
    // Region 2: cylinder whose x reciprocal is negative (huge); region 3 void.
    add_row(mk(prsf_pkg::CMD_KIND, 3'd2, 3'd0, 32'(prsf_pkg::KIND_CYL)), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd2, 3'd0, 32'h80000000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd2, 3'd1, 32'h00400000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd2, 3'd2, 32'h80000000), 0, '0);
    add_row(mk(prsf_pkg::CMD_BOUND, 3'd2, 3'd3, 32'h7fffffff), 0, '0);
    add_row(mk(prsf_pkg::CMD_KIND, 3'd3, 3'd0, 32'(prsf_pkg::KIND_VOID)), 0, '0);
    for (int w = 0; w < prsf_pkg::WORDS_PER_REGION; w++)
      add_row(mk(prsf_pkg::CMD_BOUND, 3'd3, 3'(w),
                 (w % 2) ? 32'h00020000 : 32'hfffe0000), 0, '0);
    foreach (stim_rows[i]) begin
      rw = stim_rows[i];
      send_item(rw.it, rw.known, rw.res);
    end
    drain();

    // Four regions active; the saturating count is tried later.
    write_reg(prsf_pkg::REG_COUNT, 64'd4);
    write_reg(prsf_pkg::REG_MASK, 64'h8000_0000_0000_0001);
    stim_rows.delete();
    // Removed materials at both ends of the mask.
    add_row(mk_point(32'h0, 32'h0, 32'h0, 6'd0), 1, dropped);
    add_row(mk_point(32'h0, 32'h0, 32'h0, 6'd63), 1, dropped);
    // Box corner is inclusive, ellipsoid sum of exactly 1.0 is inside.
    add_row(mk_point(32'h00010000, 32'hffff0000, 32'h00010000, 6'd5), 0, '0);
    add_row(mk_point(32'h00010001, 32'h0, 32'h0, 6'd5), 0, '0);
    add_row(mk_point(32'h00010001, 32'h00010000, 32'h0, 6'd5), 0, '0);
    add_row(mk_point(32'h00030000, 32'h00030000, 32'h0, 6'd5), 0, '0);
    add_row(mk_point(32'h0, 32'h00020000, 32'h7fffffff, 6'd5), 0, '0);
    foreach (stim_rows[i]) begin
      rw = stim_rows[i];
      send_item(rw.it, rw.known, rw.res);
    end
    drain();

    // Random phases, each with its own setting and idling pattern.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        3: begin send_idle_pct = 38; recv_stall_pct = 38; end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off = 1'b1; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_reg(prsf_pkg::REG_COUNT, (phase == 0) ? 64'd8 : (phase == 5) ? 64'd15 :
                                     64'($urandom_range(0, 8)));
      write_reg(prsf_pkg::REG_MASK, (phase == 2) ? '1 : (phase == 4) ? 64'd0 :
                                    {$urandom, $urandom} & {$urandom, $urandom});
      write_reg(prsf_pkg::REG_CX, (phase == 3) ? 64'h7fffffff : 64'(rnd_coord()));
      write_reg(prsf_pkg::REG_CY, (phase == 3) ? 64'h80000000 : 64'(rnd_coord()));
      write_reg(prsf_pkg::REG_CZ, 64'(rnd_coord()));
      // Every region gets fully written so no unwritten entry is read.
      for (int r = 0; r < 8; r++) load_region(r, 2'($urandom));
      for (int k = 0; k < 55; k++) begin
        if ($urandom_range(19) == 0)
          send_item(mk(2'($urandom_range(1, 3)), 3'($urandom), 3'($urandom), $urandom));
        else
          send_item(mk_point(rnd_coord(), rnd_coord(), rnd_coord(), 6'($urandom)));
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(negedge clk);
    $display("Checked %0d classify results over directed rows and six random phases,",
             checked_count);
    $display("covering all region kinds, removal masks, saturated counts and a long stall.");
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/prsf_pkg.sv
sv/prsf_region_eval.sv
sv/point_region_slice_filter_top.sv
tb/point_region_slice_filter_top_tb.sv
